### rtl/slfpi_pkg.sv
// Shared types and constants for the sign-sign LMS FIR predictor inverse.
// Used by the history memory, the coefficient memory and the core top level.
// No dependencies.
`default_nettype none

package slfpi_pkg;

   // Sizes
   localparam int COEF_SLOTS_DEF = 32;
   localparam int HIST_DEPTH     = 32;
   localparam int HIST_AW        = $clog2(HIST_DEPTH);
   localparam int IDX_W          = 5;
   localparam int DATA_W         = 32;
   localparam int COEF_W         = 16;

   // Special orders and position limit
   localparam logic [IDX_W-1:0] ORDER_DIFF = 5'h1f;
   localparam logic [5:0]       POS_MAX    = 6'd63;

   // Configuration register indexes
   localparam logic [1:0] CSR_ORDER = 2'd0;
   localparam logic [1:0] CSR_SHIFT = 2'd1;
   localparam logic [1:0] CSR_BITS  = 2'd2;

   // History memory command: push a new sample, read a tap (0 = newest)
   typedef struct packed {
      logic               push;
      logic [DATA_W-1:0]  push_data;
      logic [HIST_AW-1:0] tap;
   } hist_cmd_type;

   // Coefficient memory command: one write and one read index per cycle
   typedef struct packed {
      logic              wr;
      logic [IDX_W-1:0]  widx;
      logic [COEF_W-1:0] wdata;
      logic [IDX_W-1:0]  ridx;
   } coef_cmd_type;

endpackage

`default_nettype wire

### rtl/sign_lms_fir_predictor_inverse_core.sv
// Sign-sign LMS FIR predictor inverse: residuals in, reconstructed samples out.
// Coefficient load: no result. Copied sample: straight to the result state.
// Warm-up / difference sample: one history read, then the result. Predicted sample:
// base read, dot product (one shared multiplier, one tap per cycle), rounding, sum
// and an update walk over at most order coefficients. One item at a time.
// Reset: order 8, shift 9, width 16, position 0; memories hold undefined data.
`default_nettype none

module sign_lms_fir_predictor_inverse_core
   import slfpi_pkg::*;
#(
   parameter int COEF_SLOTS = COEF_SLOTS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input items
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_action,
   input  wire logic [IDX_W-1:0]         req_coef_index,
   input  wire logic signed [COEF_W-1:0] req_coef_value,
   input  wire logic signed [DATA_W-1:0] req_residual,
   input  wire logic                     req_first_of_frame,
   // results
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_sample_out,
   // configuration writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [5:0]               csr_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_HWAIT = 8'b0000_0010,
      ST_BWAIT = 8'b0000_0100,
      ST_DOT   = 8'b0000_1000,
      ST_ROUND = 8'b0001_0000,
      ST_SUM   = 8'b0010_0000,
      ST_WALK  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  order_ff, order_in;
   logic [3:0]        shift_ff, shift_in;
   logic [5:0]        bits_ff, bits_in;
   logic [5:0]        pos_ff, pos_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] base_ff, base_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic              prod_v_ff, prod_v_in;
   logic              rd_v_ff, rd_v_in;
   logic [IDX_W-1:0]  dot_j_ff, dot_j_in;
   logic [DATA_W-1:0] sh_ff, sh_in;
   logic [DATA_W-1:0] s_ff, s_in;
   logic [DATA_W-1:0] err_ff, err_in;
   logic              neg_mode_ff, neg_mode_in;
   logic [IDX_W-1:0]  pn_ff, pn_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   hist_cmd_type      hist_cmd;
   coef_cmd_type      coef_cmd;
   logic [DATA_W-1:0] hist_rdata;
   logic [COEF_W-1:0] coef_rdata;

   // datapath temporaries
   logic [5:0]              pos_eff;
   logic                    dot_issue;
   logic signed [DATA_W-1:0] diff;
   logic signed [47:0]      mac_full;
   logic [DATA_W-1:0]       rnd_sum;
   logic [DATA_W-1:0]       v_raw;
   logic [DATA_W-1:0]       v_mag;
   logic                    v_pos;
   logic                    v_neg;
   logic                    flip;
   logic [DATA_W-1:0]       v_q;
   logic [IDX_W-1:0]        weight;
   logic [36:0]             term_full;
   logic [DATA_W-1:0]       err_next;
   logic                    walk_go;

   // sign-extend from bit width; 0 or 32 and up leaves the word as is
   function automatic logic [DATA_W-1:0] sext_to(input logic [DATA_W-1:0] v,
                                                 input logic [5:0] bits);
      logic [5:0]        sh;
      logic [DATA_W-1:0] r;
      sh = 6'd32 - bits;
      if (bits == 6'd0 || bits >= 6'd32) begin
         r = v;
      end else begin
         r = DATA_W'($signed(v << sh) >>> sh);
      end
      return r;
   endfunction

   // memories
   slfpi_hist_mem u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (hist_cmd),
      .rd_data (hist_rdata)
   );

   slfpi_coef_mem #(
      .COEF_SLOTS (COEF_SLOTS)
   ) u_coef (
      .clock   (clock),
      .cmd     (coef_cmd),
      .rd_data (coef_rdata)
   );

   // handshakes
   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // dot product arithmetic
   assign diff     = $signed(hist_rdata - base_ff);
   assign mac_full = diff * $signed(coef_rdata);
   assign rnd_sum  = sum_ff + ((DATA_W'(1) << shift_ff) >> 1);

   // update walk arithmetic
   assign v_raw     = base_ff - hist_rdata;
   assign v_pos     = (v_raw != '0) && !v_raw[DATA_W-1];
   assign v_neg     = v_raw[DATA_W-1];
   assign flip      = neg_mode_ff ? v_pos : v_neg;
   assign v_mag     = flip ? (DATA_W'(0) - v_raw) : v_raw;
   assign v_q       = DATA_W'($signed(v_mag) >>> shift_ff);
   assign weight    = order_ff - pn_ff;
   assign term_full = v_q * weight;
   assign err_next  = err_ff - term_full[DATA_W-1:0];
   assign walk_go   = neg_mode_ff ? err_next[DATA_W-1]
                                  : ((err_next != '0) && !err_next[DATA_W-1]);

   assign pos_eff   = req_first_of_frame ? 6'd0 : pos_ff;
   assign dot_issue = dot_j_ff < order_ff;

   // control and datapath next state
   always_comb begin
      state_in     = state_ff;
      order_in     = order_ff;
      shift_in     = shift_ff;
      bits_in      = bits_ff;
      pos_in       = pos_ff;
      res_in       = res_ff;
      base_in      = base_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      prod_v_in    = 1'b0;
      rd_v_in      = 1'b0;
      dot_j_in     = dot_j_ff;
      sh_in        = sh_ff;
      s_in         = s_ff;
      err_in       = err_ff;
      neg_mode_in  = neg_mode_ff;
      pn_in        = pn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      hist_cmd     = '0;
      coef_cmd     = '0;

      // configuration beats
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ORDER: order_in = csr_data[IDX_W-1:0];
            CSR_SHIFT: shift_in = csr_data[3:0];
            CSR_BITS:  bits_in  = csr_data;
            default:   ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_action) begin
                  // coefficient load
                  coef_cmd.wr    = 1'b1;
                  coef_cmd.widx  = req_coef_index;
                  coef_cmd.wdata = req_coef_value;
               end else begin
                  res_in = req_residual;
                  pos_in = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 6'd1;
                  priority if (pos_eff == 6'd0 || order_ff == '0) begin
                     s_in     = req_residual;
                     state_in = ST_DONE;
                  end else if (order_ff == ORDER_DIFF || pos_eff <= {1'b0, order_ff}) begin
                     hist_cmd.tap = '0;
                     state_in     = ST_HWAIT;
                  end else begin
                     hist_cmd.tap = order_ff;
                     state_in     = ST_BWAIT;
                  end
               end
            end
         end

         ST_HWAIT: begin
            s_in     = sext_to(hist_rdata + res_ff, bits_ff);
            state_in = ST_DONE;
         end

         ST_BWAIT: begin
            base_in  = hist_rdata;
            sum_in   = '0;
            dot_j_in = '0;
            state_in = ST_DOT;
         end

         // one tap issued per cycle: read, multiply, accumulate
         ST_DOT: begin
            hist_cmd.tap  = dot_j_ff;
            coef_cmd.ridx = dot_j_ff;
            rd_v_in       = dot_issue;
            if (dot_issue) begin
               dot_j_in = dot_j_ff + IDX_W'(1);
            end
            if (rd_v_ff) begin
               prod_in   = mac_full[DATA_W-1:0];
               prod_v_in = 1'b1;
            end
            if (prod_v_ff) begin
               sum_in = sum_ff + prod_ff;
            end
            if (!dot_issue && !rd_v_ff && !prod_v_ff) begin
               state_in = ST_ROUND;
            end
         end

         ST_ROUND: begin
            sh_in    = DATA_W'($signed(rnd_sum) >>> shift_ff);
            state_in = ST_SUM;
         end

         // form the sample and, for a nonzero residual, start the update walk at the highest tap
         ST_SUM: begin
            s_in          = sext_to(sh_ff + base_ff + res_ff, bits_ff);
            err_in        = res_ff;
            neg_mode_in   = res_ff[DATA_W-1];
            pn_in         = order_ff - IDX_W'(1);
            hist_cmd.tap  = order_ff - IDX_W'(1);
            coef_cmd.ridx = order_ff - IDX_W'(1);
            state_in      = (res_ff == '0) ? ST_DONE : ST_WALK;
         end

         // data for pn is here; the read for pn-1 is issued ahead
         ST_WALK: begin
            hist_cmd.tap   = pn_ff - IDX_W'(1);
            coef_cmd.ridx  = pn_ff - IDX_W'(1);
            coef_cmd.wr    = (v_raw != '0);
            coef_cmd.widx  = pn_ff;
            coef_cmd.wdata = flip ? coef_rdata + COEF_W'(1)
                                  : coef_rdata - COEF_W'(1);
            err_in         = err_next;
            if (walk_go && pn_ff != '0) begin
               pn_in = pn_ff - IDX_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end

         // once the output register is free, hand the sample over and shift it into the history
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in        = s_ff;
               hist_cmd.push      = 1'b1;
               hist_cmd.push_data = s_ff;
               state_in           = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= IDX_W'(8);
         shift_ff     <= 4'd9;
         bits_ff      <= 6'd16;
         pos_ff       <= '0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         shift_ff     <= shift_in;
         bits_ff      <= bits_in;
         pos_ff       <= pos_in;
         rd_v_ff      <= rd_v_in;
         prod_v_ff    <= prod_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      base_ff     <= base_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      dot_j_ff    <= dot_j_in;
      sh_ff       <= sh_in;
      s_ff        <= s_in;
      err_ff      <= err_in;
      neg_mode_ff <= neg_mode_in;
      pn_ff       <= pn_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### rtl/slfpi_hist_mem.sv
// Circular history buffer of reconstructed samples, one synchronous memory.
// Tap k reads the k-th newest sample; read data is registered and arrives in the next cycle.
// Depends on slfpi_pkg.
`default_nettype none

module slfpi_hist_mem
   import slfpi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hist_cmd_type      cmd,
   output logic [DATA_W-1:0]      rd_data
);

   logic [DATA_W-1:0]  mem [HIST_DEPTH];
   logic [HIST_AW-1:0] head_ff;
   logic [HIST_AW-1:0] head_in;
   logic [HIST_AW-1:0] wr_addr;
   logic [HIST_AW-1:0] rd_addr;
   logic [DATA_W-1:0]  rd_data_ff;

   // head points at the newest entry; a push lands one slot further
   assign wr_addr = head_ff + HIST_AW'(1);
   assign rd_addr = head_ff - cmd.tap;
   assign head_in = cmd.push ? wr_addr : head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   // memory array, registered read
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= cmd.push_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/slfpi_coef_mem.sv
// Adapting coefficient table, one synchronous memory with registered read.
// Slots at or above COEF_SLOTS read as zero and drop writes.
// Depends on slfpi_pkg.
`default_nettype none

module slfpi_coef_mem
   import slfpi_pkg::*;
#(
   parameter int COEF_SLOTS = COEF_SLOTS_DEF
) (
   input  wire logic          clock,
   input  wire coef_cmd_type  cmd,
   output logic [COEF_W-1:0]  rd_data
);

   localparam int SLOT_W = $clog2(COEF_SLOTS);

   logic [COEF_W-1:0] mem [COEF_SLOTS];
   logic              wr_ok;
   logic              rd_ok;
   logic [SLOT_W-1:0] rd_addr;
   logic [COEF_W-1:0] rd_data_ff;
   logic              rd_ok_ff;

   // range checks against the slot count
   assign wr_ok   = cmd.wr && (int'(cmd.widx) < COEF_SLOTS);
   assign rd_ok   = int'(cmd.ridx) < COEF_SLOTS;
   assign rd_addr = rd_ok ? cmd.ridx[SLOT_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[cmd.widx[SLOT_W-1:0]] <= cmd.wdata;
      end
      rd_data_ff <= mem[rd_addr];
      rd_ok_ff   <= rd_ok;
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire
